// ----- hdl/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BDS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BDS_ASSERT_SAME(label, clk, rst, ante, cons)
`define BDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/bds_pkg.sv -----
// shared types and constants of the 2x2 box downsampler
`timescale 1ns / 1ps
`default_nettype none
package bds_pkg;

  localparam int CFG_INDEX_W        = 2;
  localparam int CFG_DATA_W         = 15;
  localparam int FRAME_WIDTH_W      = 13;
  localparam int FRAME_HEIGHT_W     = 15;
  localparam int ROW_W              = 14;
  localparam int VALUE_W            = 16;
  localparam int MAX_HEIGHT         = 16384;
  localparam int FRAME_WIDTH_RESET  = 4096;
  localparam int FRAME_HEIGHT_RESET = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage
`default_nettype wire

// ----- hdl/bds_line_ram.sv -----
// line store of horizontal pair sums, one write port and a registered read port
`timescale 1ns / 1ps
`default_nettype none
module bds_line_ram #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 17,
  parameter int ADDR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/box_downsample_2x2.sv -----
// top level of the streaming 2x2 box downsampler
// a block's result passes through the middle stage and then the result register after its bottom-right pixel beat
// throughput: one pixel beat per cycle while the middle stage can move; the single line store port pair sets this
// a full output register does not stop input while the middle stage can move
// reset (rst, synchronous): counters, held pixel and pipeline cleared,
// width set to 4096 (clamped to MAX_WIDTH), height set to 1; line store not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module box_downsample_2x2 #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bds_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [bds_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [bds_pkg::VALUE_W-1:0]        pixel_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [bds_pkg::VALUE_W-1:0]        avg_value,
  output logic                                    out_last
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW         = $clog2(MAX_WIDTH + 1);
  localparam int HW         = bds_pkg::FRAME_HEIGHT_W;
  localparam int ROW_W      = bds_pkg::ROW_W;
  localparam int PW         = PIXEL_BITS + 1;
  localparam int SW         = PIXEL_BITS + 2;
  localparam int RESET_W    = (MAX_WIDTH < bds_pkg::FRAME_WIDTH_RESET) ?
                              MAX_WIDTH : bds_pkg::FRAME_WIDTH_RESET;

  // configuration, held as effective dimensions
  logic [EW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [EW-1:0] eff_w_next;
  logic [HW-1:0] eff_h_next;
  logic [14:0]   w_raw;
  logic [14:0]   h_raw;

  assign cfg_ready = 1'b1;
  assign w_raw = {2'b00, cfg_data[bds_pkg::FRAME_WIDTH_W-1:0]};
  assign h_raw = cfg_data[HW-1:0];

  always_comb begin
    eff_w_next = eff_w;
    eff_h_next = eff_h;
    unique case (cfg_index)
      bds_pkg::REG_FRAME_WIDTH: begin
        if (w_raw == 15'd0) begin
          eff_w_next = EW'(1);
        end else if (w_raw > 15'(MAX_WIDTH)) begin
          eff_w_next = EW'(MAX_WIDTH);
        end else begin
          eff_w_next = EW'(w_raw);
        end
      end
      bds_pkg::REG_FRAME_HEIGHT: begin
        if (h_raw == 15'd0) begin
          eff_h_next = HW'(1);
        end else if (h_raw > 15'(bds_pkg::MAX_HEIGHT)) begin
          eff_h_next = HW'(bds_pkg::MAX_HEIGHT);
        end else begin
          eff_h_next = h_raw;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= EW'(RESET_W);
      eff_h <= HW'(bds_pkg::FRAME_HEIGHT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      eff_w <= eff_w_next;
      eff_h <= eff_h_next;
    end
  end

  // frame position and decode of the incoming pixel
  logic [COL_W-1:0]      col;
  logic [ROW_W-1:0]      row;
  logic [PIXEL_BITS-1:0] held;
  logic [PIXEL_BITS-1:0] pix;
  logic [EW-1:0]         out_w;
  logic [HW-1:0]         out_h;
  logic                  w_one;
  logic                  h_one;
  logic                  last_col;
  logic                  last_row;
  logic                  have_pair;
  logic                  emit;
  logic                  use_above;
  logic                  line_wr;
  logic                  blk_last;
  logic [PW-1:0]         pair;
  logic [1:0]            shift;
  logic [COL_W-1:0]      idx;
  logic [ROW_W-1:0]      orow;
  logic                  accept;
  logic                  advance;

  assign pix       = pixel_value[PIXEL_BITS-1:0];
  assign out_w     = ((eff_w >> 1) == EW'(0)) ? EW'(1) : (eff_w >> 1);
  assign out_h     = ((eff_h >> 1) == HW'(0)) ? HW'(1) : (eff_h >> 1);
  assign w_one     = (eff_w == EW'(1));
  assign h_one     = (eff_h == HW'(1));
  assign last_col  = ((EW+1)'(col) + (EW+1)'(1)) >= (EW+1)'(eff_w);
  assign last_row  = ((HW+1)'(row) + (HW+1)'(1)) >= (HW+1)'(eff_h);
  assign have_pair = w_one || col[0];
  assign pair      = w_one ? PW'(pix) : (PW'(held) + PW'(pix));
  assign emit      = have_pair && (h_one || row[0]);
  assign use_above = have_pair && !h_one && row[0];
  assign line_wr   = have_pair && !h_one && !row[0] && !last_row;
  assign shift     = {1'b0, !w_one} + {1'b0, use_above};
  assign idx       = col >> 1;
  assign orow      = row >> 1;
  assign blk_last  = (((EW+1)'(idx) + (EW+1)'(1)) >= (EW+1)'(out_w)) &&
                     (((HW+1)'(orow) + (HW+1)'(1)) >= (HW+1)'(out_h));

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      held <= '0;
    end else if (accept) begin
      if (!w_one && !col[0] && !last_col) begin
        held <= pix;
      end
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : (row + ROW_W'(1));
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // line store
  logic [PW-1:0] above;

  bds_line_ram #(
    .DEPTH  (LINE_DEPTH),
    .DATA_W (PW),
    .ADDR_W (ADDR_W)
  ) u_line (
    .clk     (clk),
    .wr_en   (accept && line_wr),
    .wr_addr (idx[ADDR_W-1:0]),
    .wr_data (pair),
    .rd_en   (accept && use_above),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (above)
  );

  // middle stage: pair sum waiting for the line store read
  logic          s1_valid;
  logic [PW-1:0] s1_pair;
  logic [1:0]    s1_shift;
  logic          s1_above;
  logic          s1_last;
  logic [SW-1:0] s1_sum;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emit;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pair  <= pair;
      s1_shift <= shift;
      s1_above <= use_above;
      s1_last  <= blk_last;
    end
  end

  assign s1_sum = SW'(s1_pair) + (s1_above ? SW'(above) : SW'(0));

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      avg_value <= bds_pkg::VALUE_W'(s1_sum >> s1_shift);
      out_last  <= s1_last;
    end
  end

  `BDS_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !advance, s1_valid)
  `BDS_ASSERT_NEXT(a_above_hold, clk, rst, s1_valid && !advance, $stable(above))
  `BDS_ASSERT_SAME(a_ready_free, clk, rst, !out_valid, in_ready)

endmodule
`default_nettype wire
